/* rtl/bandlimited_additive_waveform_macros.svh */
// Assertion macros shared by the band-limited additive waveform RTL.
`ifndef BANDLIMITED_ADDITIVE_WAVEFORM_MACROS_SVH
`define BANDLIMITED_ADDITIVE_WAVEFORM_MACROS_SVH
`ifndef SYNTH
// Condition that must hold in the same cycle as its trigger.
`define BAW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Condition that must hold in the cycle after its trigger.
`define BAW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BAW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define BAW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/baw_pkg.sv */
// Constants and table builders for the band-limited additive waveform block.
package baw_pkg;

  // Default configuration of the block.
  localparam int MAX_HARMONICS_DEF   = 128;
  localparam int PHASE_BITS_DEF      = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Fixed-point constants, all Q30.
  localparam longint unsigned Q30_ONE      = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned SAW_GAIN_Q30 = 64'd683565276;
  localparam longint unsigned SQR_GAIN_Q30 = 64'd1367130551;
  localparam longint unsigned TRI_GAIN_Q30 = 64'd870342340;

  // Output range of the Q3.20 sample.
  localparam int OUT_MAX     = 8388607;
  localparam int OUT_MIN_MAG = 8388608;

  // Waveform codes of the wave_select register.
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SAW      = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

  // Taylor series divisors (2n)(2n+1) for n = 1 .. 12.
  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Quarter-wave sine value in Q30 for step j of a 2^qbits quarter, used only
  // at elaboration to build the sine table.
  function automatic longint quarter_sine(input longint unsigned j,
                                          input int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x = (HALF_PI_Q30 * j + (64'd1 << (qbits - 1))) >> qbits;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      if (term != 64'd0) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[n];
        if (n[0] == 1'b0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(Q30_ONE)) begin
      sum = longint'(Q30_ONE);
    end
    return sum;
  endfunction

endpackage

/* rtl/bandlimited_additive_waveform.sv */
// Band-limited additive oscillator: truncated Fourier sum over harmonics.
//
// Usage: write wave_select through cfg_valid/cfg_data (cfg_ready is always
// high) while the block is idle: 0 sine, 1 sawtooth, 2 square, 3 triangle.
// An item (phase, harmonic_limit) is taken on a clock edge with start high
// and busy low. busy stays high until the result is out; sample is valid for
// the single cycle in which done is high, and the receiver cannot stall it.
// Each harmonic is issued into a short pipeline: sine table and coefficient
// lookup, one shared multiplier, rounding, and one shared accumulator. One
// harmonic enters per cycle. The summed harmonic count is set by
// harmonic_limit saturated to MAX_HARMONICS. A new item may be started in
// the cycle done is high.
// Reset returns the sequencer to idle and wave_select to sine. Tables are
// constants, so no setup pass follows reset.
`include "bandlimited_additive_waveform_macros.svh"

module bandlimited_additive_waveform #(
  parameter int MAX_HARMONICS   = baw_pkg::MAX_HARMONICS_DEF,
  parameter int PHASE_BITS      = baw_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = baw_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [23:0]        phase,
  input  logic [7:0]         harmonic_limit,
  output logic               done,
  output logic signed [23:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);

  // Derived sizes.
  localparam int PW    = PHASE_BITS;
  localparam int TW    = SINE_TABLE_BITS;
  localparam int QB    = TW - 2;
  localparam int QSIZE = 2 ** QB;
  localparam int KCW   = $clog2(MAX_HARMONICS + 3);
  localparam int LW    = (KCW > 8) ? KCW : 8;
  localparam int CIW   = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int CSIZE = 2 ** CIW;
  localparam int AW    = 34 + $clog2(MAX_HARMONICS + 1);
  localparam int RW    = AW - 10;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t            state;
  logic [1:0]        wave;
  logic [KCW-1:0]    k;
  logic [KCW-1:0]    lim_eff;
  logic [PW-1:0]     ph;
  logic [PW-1:0]     pk;
  logic              v1;
  logic              v2;
  logic              v3;
  logic [30:0]       s1_mag;
  logic              s1_negs;
  logic [31:0]       s1_coef;
  logic              s1_negh;
  logic [62:0]       prod2;
  logic              neg2;
  logic [32:0]       term3;
  logic              neg3;
  logic signed [AW-1:0] acc;
  logic [RW-1:0]     rnd;
  logic              rneg;

  logic              accept;
  logic              issue;
  logic [LW-1:0]     lim_ext;
  logic [LW-1:0]     lim_sat;
  logic [KCW-1:0]    lim_start;
  logic              odd_only;
  logic [PW-1:0]     step_ph;
  logic [TW-1:0]     addr;
  logic [QB-1:0]     qj;
  logic [QB:0]       qidx;
  logic [CIW-1:0]    cidx;
  logic [31:0]       coef;
  logic              negh;
  logic [62:0]       prod_w;
  logic [62:0]       round_w;
  logic [AW-1:0]     acc_mag;
  logic [AW-1:0]     acc_rnd;

  logic [30:0]       qtab    [QSIZE+1];
  logic [31:0]       saw_tab [CSIZE];
  logic [31:0]       sqr_tab [CSIZE];
  logic [31:0]       tri_tab [CSIZE];

  // Quarter-wave sine table, Q30, built at elaboration.
  for (genvar g = 0; g <= QSIZE; g++) begin : g_qtab
    localparam longint QV = baw_pkg::quarter_sine(g, QB);
    assign qtab[g] = 31'(QV);
  end

  // Harmonic coefficient tables, gain/k and gain/k^2 rounded half up.
  for (genvar g = 0; g < CSIZE; g++) begin : g_coef
    localparam longint unsigned KV  = (g == 0) ? 64'd1 : 64'(g);
    localparam longint unsigned KV2 = KV * KV;
    localparam logic [31:0] SAWC = (g == 0 || g >= MAX_HARMONICS) ? 32'd0 :
      32'((baw_pkg::SAW_GAIN_Q30 + KV / 2) / KV);
    localparam logic [31:0] SQRC = (g == 0 || g >= MAX_HARMONICS) ? 32'd0 :
      32'((baw_pkg::SQR_GAIN_Q30 + KV / 2) / KV);
    localparam logic [31:0] TRIC = (g == 0 || g >= MAX_HARMONICS) ? 32'd0 :
      32'((baw_pkg::TRI_GAIN_Q30 + KV2 / 2) / KV2);
    assign saw_tab[g] = SAWC;
    assign sqr_tab[g] = SQRC;
    assign tri_tab[g] = TRIC;
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign issue     = (state == S_RUN) && (k < lim_eff);

  // Harmonic limit saturation; a sine item runs the first harmonic only.
  assign lim_ext = LW'(harmonic_limit);
  assign lim_sat = (lim_ext > LW'(MAX_HARMONICS)) ? LW'(MAX_HARMONICS) : lim_ext;
  always_comb begin
    if (wave == baw_pkg::WAVE_SINE) begin
      lim_start = (lim_sat != '0) ? KCW'(2) : '0;
    end else begin
      lim_start = KCW'(lim_sat);
    end
  end

  // Square and triangle visit odd harmonics only.
  assign odd_only = (wave == baw_pkg::WAVE_SQUARE) || (wave == baw_pkg::WAVE_TRIANGLE);
  assign step_ph  = odd_only ? (ph << 1) : ph;

  // Sine table address from the top bits of the harmonic phase.
  if (PW >= TW) begin : g_addr_trunc
    assign addr = pk[PW-1 -: TW];
  end else begin : g_addr_shift
    assign addr = {pk, (TW - PW)'(0)};
  end

  // Fold the full-wave address onto the quarter table.
  assign qj   = addr[QB-1:0];
  assign qidx = addr[TW-2] ? ((QB + 1)'(QSIZE) - {1'b0, qj}) : {1'b0, qj};
  assign cidx = CIW'(k);

  // Coefficient and sign of the current harmonic.
  always_comb begin
    case (wave)
      baw_pkg::WAVE_SINE: begin
        coef = 32'(baw_pkg::Q30_ONE);
        negh = 1'b0;
      end
      baw_pkg::WAVE_SAW: begin
        coef = saw_tab[cidx];
        negh = !k[0];
      end
      baw_pkg::WAVE_SQUARE: begin
        coef = sqr_tab[cidx];
        negh = 1'b0;
      end
      baw_pkg::WAVE_TRIANGLE: begin
        coef = tri_tab[cidx];
        negh = k[1] && k[0];
      end
      default: begin
        coef = 32'd0;
        negh = 1'b0;
      end
    endcase
  end

  // Shared multiplier and rounding of the Q60 product back to Q30.
  assign prod_w  = s1_mag * s1_coef;
  assign round_w = prod2 + 63'(64'd1 << 29);

  // Rounding of the accumulator to Q3.20, half away from zero.
  assign acc_mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign acc_rnd = acc_mag + AW'(512);

  // Sequencer and valid bits of the harmonic pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wave    <= baw_pkg::WAVE_SINE;
      k       <= '0;
      lim_eff <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= (state == S_EMIT);
      v1   <= issue;
      v2   <= v1;
      v3   <= v2;
      if (cfg_valid && cfg_ready) begin
        wave <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            k       <= KCW'(1);
            lim_eff <= lim_start;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            k <= k + (odd_only ? KCW'(2) : KCW'(1));
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: phase stepping, pipeline stages, accumulator, output.
  always_ff @(posedge clk) begin
    if (accept) begin
      ph  <= PW'(phase);
      pk  <= PW'(phase);
      acc <= '0;
    end else begin
      if (issue) begin
        pk <= pk + step_ph;
      end
      if (v3) begin
        acc <= neg3 ? (acc - AW'(term3)) : (acc + AW'(term3));
      end
    end
    s1_mag  <= qtab[qidx];
    s1_negs <= addr[TW-1];
    s1_coef <= coef;
    s1_negh <= negh;
    prod2   <= prod_w;
    neg2    <= s1_negs ^ s1_negh;
    term3   <= round_w[62:30];
    neg3    <= neg2;
    if (state == S_DRAIN) begin
      rnd  <= acc_rnd[AW-1:10];
      rneg <= acc[AW-1];
    end
    if (state == S_EMIT) begin
      if (!rneg && (rnd > RW'(baw_pkg::OUT_MAX))) begin
        sample <= 24'sh7FFFFF;
      end else if (rneg && (rnd > RW'(baw_pkg::OUT_MIN_MAG))) begin
        sample <= 24'sh800000;
      end else begin
        sample <= rneg ? $signed(-rnd[23:0]) : $signed(rnd[23:0]);
      end
    end
  end

  // Checks on the sequencer and the harmonic pipeline.
  `BAW_ASSERT_NEXT(a_accept_runs, clk, rst, accept, state == S_RUN,
    "accepted item did not start the harmonic run")
  `BAW_ASSERT_NEXT(a_emit_done, clk, rst, state == S_EMIT, done && !busy,
    "result was not strobed after the emit step")
  `BAW_ASSERT_SAME(a_idle_empty, clk, rst, state == S_IDLE, !v1 && !v2 && !v3,
    "harmonic pipeline still busy while idle")
  `BAW_ASSERT_NEXT(a_issue_in_run, clk, rst, state != S_RUN, !v1,
    "harmonic issued outside the run state")

endmodule

/* tb/tb_bandlimited_additive_waveform.sv */
// Self-checking testbench for the band-limited additive waveform oscillator.
module tb_bandlimited_additive_waveform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HARM      = baw_pkg::MAX_HARMONICS_DEF;
  localparam int PH_BITS   = baw_pkg::PHASE_BITS_DEF;
  localparam int LUT_BITS  = baw_pkg::SINE_TABLE_BITS_DEF;
  localparam int LUT_SIZE  = 1 << LUT_BITS;
  localparam int QBITS     = LUT_BITS - 2;
  localparam int QSIZE     = LUT_SIZE >> 2;
  localparam longint unsigned PH_MASK = (64'd1 << PH_BITS) - 64'd1;
  localparam int SAMPLE_MAX = baw_pkg::OUT_MAX;
  localparam int SAMPLE_MIN = -baw_pkg::OUT_MIN_MAG;
  localparam int SEGMENTS  = 12;
  localparam int SEG_ITEMS = 50;
  localparam int DRAIN_CYCLES = 150;

  // Predicts each sample from its own sine and coefficient tables and holds the
  // samples still owed by the block.
  class fourier_scoreboard;
    int sine_lut[LUT_SIZE];
    longint unsigned saw_coef[HARM];
    longint unsigned sqr_coef[HARM];
    longint unsigned tri_coef[HARM];
    logic [1:0] wave_sel;
    logic signed [23:0] owed_samples[$];
    int errors;

    function new();
      int quad;
      int j;
      longint v;
      longint unsigned k2;
      for (int i = 0; i < LUT_SIZE; i++) begin
        quad = i >> QBITS;
        j = i & (QSIZE - 1);
        v = (quad & 1) ? quarter_wave(QSIZE - j) : quarter_wave(j);
        sine_lut[i] = int'((quad >= 2) ? -v : v);
      end
      saw_coef[0] = 0;
      sqr_coef[0] = 0;
      tri_coef[0] = 0;
      for (int k = 1; k < HARM; k++) begin
        k2 = 64'(k) * 64'(k);
        saw_coef[k] = (baw_pkg::SAW_GAIN_Q30 + 64'(k / 2)) / 64'(k);
        sqr_coef[k] = (baw_pkg::SQR_GAIN_Q30 + 64'(k / 2)) / 64'(k);
        tri_coef[k] = (baw_pkg::TRI_GAIN_Q30 + k2 / 2) / k2;
      end
      wave_sel = baw_pkg::WAVE_SINE;
      errors = 0;
    endfunction

    // Quarter-wave sine in Q30 from a Taylor series on a Q30 angle.
    function longint quarter_wave(int j);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned t;
      longint acc;
      ang = (baw_pkg::HALF_PI_Q30 * 64'(j) + (64'd1 << (QBITS - 1))) >> QBITS;
      ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
      t = ang;
      acc = longint'(ang);
      for (int n = 1; n <= 12 && t != 0; n++) begin
        t = (t * ang_sq) >> 30;
        t = t / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(t);
        end else begin
          acc = acc + longint'(t);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > longint'(baw_pkg::Q30_ONE)) begin
        acc = longint'(baw_pkg::Q30_ONE);
      end
      return acc;
    endfunction

    // Right shift with rounding of the magnitude, half away from zero.
    function longint round_shift(longint v, int s);
      longint unsigned mag;
      longint unsigned r;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      r = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Table address of harmonic k: top bits of the wrapped phase product.
    function int lut_index(logic [23:0] ph, int k);
      longint unsigned turn;
      turn = (longint'(ph) * k) & PH_MASK;
      return int'(turn >> (PH_BITS - LUT_BITS));
    endfunction

    // Work out the sample owed for an accepted item.
    function void note_item(logic [23:0] ph, logic [7:0] limit);
      int lim;
      int step;
      longint sum;
      longint term;
      longint coef;
      bit neg;
      lim = (int'(limit) > HARM) ? HARM : int'(limit);
      sum = 0;
      if (wave_sel == baw_pkg::WAVE_SINE) begin
        if (lim >= 1) begin
          sum = sine_lut[lut_index(ph, 1)];
        end
      end else begin
        step = (wave_sel == baw_pkg::WAVE_SAW) ? 1 : 2;
        for (int k = 1; k < lim; k += step) begin
          case (wave_sel)
            baw_pkg::WAVE_SAW: begin
              coef = longint'(saw_coef[k]);
              neg = (k % 2 == 0);
            end
            baw_pkg::WAVE_SQUARE: begin
              coef = longint'(sqr_coef[k]);
              neg = 1'b0;
            end
            default: begin
              coef = longint'(tri_coef[k]);
              neg = (k % 4 == 3);
            end
          endcase
          term = round_shift(longint'(sine_lut[lut_index(ph, k)]) * coef, 30);
          sum = neg ? sum - term : sum + term;
        end
      end
      sum = round_shift(sum, 10);
      if (sum > SAMPLE_MAX) begin
        sum = SAMPLE_MAX;
      end
      if (sum < SAMPLE_MIN) begin
        sum = SAMPLE_MIN;
      end
      owed_samples.push_back(sum[23:0]);
    endfunction

    // Compare a delivered sample with the oldest one owed.
    function void check_result(logic signed [23:0] got);
      logic signed [23:0] want;
      if (owed_samples.size() == 0) begin
        $error("sample: expected none, got %0d", got);
        errors++;
        return;
      end
      want = owed_samples.pop_front();
      if (got !== want) begin
        $error("sample: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return owed_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [23:0] phase;
  logic [7:0] harmonic_limit;
  logic done;
  logic signed [23:0] sample;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_data;

  fourier_scoreboard sb;
  int idle_pct;

  bandlimited_additive_waveform uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .phase(phase),
    .harmonic_limit(harmonic_limit),
    .done(done),
    .sample(sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every done pulse carries one sample that must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      sb.check_result(sample);
    end
  end

  // Present one item, with a random gap first, and hold it until accepted.
  // Called and returns at a falling edge; start stays high afterward so
  // back-to-back items need no dead cycle.
  task automatic send_item(input logic [23:0] ph, input logic [7:0] lim);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start = 1'b1;
    phase = ph;
    harmonic_limit = lim;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(ph, lim);
    @(negedge clk);
  endtask

  // Write the waveform register once every owed sample has come back.
  task automatic set_wave(input logic [1:0] w);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = w;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.wave_sel = w;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random item: limits lean toward the small, edge and saturating cases.
  task automatic send_random_item();
    logic [23:0] ph;
    logic [7:0] lim;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      lim = 8'($urandom_range(3));
    end else if (pick < 30) begin
      lim = 8'($urandom_range(255, HARM + 1));
    end else if (pick < 40) begin
      lim = 8'($urandom_range(HARM, HARM - 4));
    end else begin
      lim = 8'($urandom_range(HARM));
    end
    pick = $urandom_range(99);
    if (pick < 3) begin
      ph = 24'h000000;
    end else if (pick < 6) begin
      ph = 24'hFFFFFF;
    end else if (pick < 10) begin
      ph = 24'($urandom_range(3)) << 22;
    end else begin
      ph = 24'($urandom());
    end
    send_item(ph, lim);
  endtask

  // Directed items run under each waveform: phase extremes, zero and one
  // harmonic, a full sum and limits past the maximum.
  localparam logic [23:0] DIR_PHASE [6] = '{
    24'h000000, 24'hFFFFFF, 24'h400000, 24'h800000, 24'h555555, 24'hFFFFFF
  };
  localparam logic [7:0] DIR_LIMIT [6] = '{8'd0, 8'd1, 8'd2, 8'd128, 8'd129, 8'd255};
  localparam logic [1:0] WAVE_ORDER [4] = '{
    baw_pkg::WAVE_SINE, baw_pkg::WAVE_SAW, baw_pkg::WAVE_SQUARE, baw_pkg::WAVE_TRIANGLE
  };
  // Sender idle percentage per phase; the receiver cannot stall, so its
  // phase runs without gaps.
  localparam int IDLE_MODES [4] = '{0, 84, 0, 35};

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    phase = '0;
    harmonic_limit = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed part; sine relies on the reset value of the register.
    for (int w = 0; w < 4; w++) begin
      if (w != 0) begin
        set_wave(WAVE_ORDER[w]);
      end
      for (int i = 0; i < 6; i++) begin
        send_item(DIR_PHASE[i], DIR_LIMIT[i]);
      end
    end

    // Random part: each waveform meets three of the four idling modes.
    for (int s = 0; s < SEGMENTS; s++) begin
      set_wave(WAVE_ORDER[(s + s / 4) % 4]);
      idle_pct = IDLE_MODES[s % 4];
      for (int i = 0; i < SEG_ITEMS; i++) begin
        send_random_item();
      end
    end

    // Drain the owed samples, then watch for stray pulses.
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
